// ----- sv/fwpe_pkg.sv -----
// Shared types and codes for the priority-extraction message queue.
`default_nettype none
package fwpe_pkg;

  localparam int PRIO_BITS = 8;

  typedef logic [2:0]           action_t;
  typedef logic [1:0]           status_t;
  typedef logic [PRIO_BITS-1:0] prio_t;

  localparam action_t ACT_PUSH      = 3'd0;
  localparam action_t ACT_POP_FRONT = 3'd1;
  localparam action_t ACT_POP_EXACT = 3'd2;
  localparam action_t ACT_POP_MIN   = 3'd3;
  localparam action_t ACT_CLEAR     = 3'd4;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

endpackage
`default_nettype wire

// ----- sv/fwpe_in_if.sv -----
// Request channel interface of the message queue.
`default_nettype none
interface fwpe_in_if #(
  parameter int PAYLOAD_BITS = 32
);
  import fwpe_pkg::*;

  logic                    valid;
  logic                    ready;
  action_t                 action;
  prio_t                   priority_req;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, action, priority_req, payload, input ready);
  modport sink   (input valid, action, priority_req, payload, output ready);
endinterface
`default_nettype wire

// ----- sv/fwpe_out_if.sv -----
// Result channel interface of the message queue.
`default_nettype none
interface fwpe_out_if #(
  parameter int PAYLOAD_BITS = 32,
  parameter int CNT_BITS     = 5
);
  import fwpe_pkg::*;

  logic                    valid;
  logic                    ready;
  status_t                 status;
  prio_t                   out_priority;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [CNT_BITS-1:0]     count;

  modport source (output valid, status, out_priority, out_payload, count, input ready);
  modport sink   (input valid, status, out_priority, out_payload, count, output ready);
endinterface
`default_nettype wire

// ----- sv/fifo_with_priority_extraction.sv -----
// Arrival-ordered message queue with pop-front, pop-by-priority and gap-closing removal.
// Push, clear, undefined actions and pops of an empty queue skip the scan and go straight
// to the done state. A pop scans slot by slot through the single-read memory port, and
// after a hit shifts later slots down one per cycle to close the gap. One item is in work
// at a time; the next is accepted once the result is registered. Reset empties the queue
// and the output register; slots are not cleared.
`default_nettype none
module fifo_with_priority_extraction #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fwpe_in_if.sink     in_ch,
  fwpe_out_if.source  out_ch
);
  import fwpe_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  prio_t                   mem_prio [DEPTH];
  logic [PAYLOAD_BITS-1:0] mem_pay  [DEPTH];

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  action_t                 act_r, act_nxt;
  prio_t                   key_r, key_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    chk_vld_r, chk_vld_nxt;
  logic [IW-1:0]           chk_idx_r, chk_idx_nxt;
  logic [CW-1:0]           src_r, src_nxt;
  logic                    wr_pend_r, wr_pend_nxt;
  logic [IW-1:0]           wr_idx_r, wr_idx_nxt;
  status_t                 res_status_r, res_status_nxt;
  prio_t                   res_prio_r, res_prio_nxt;
  logic [PAYLOAD_BITS-1:0] res_pay_r, res_pay_nxt;
  prio_t                   rd_prio_r;
  logic [PAYLOAD_BITS-1:0] rd_pay_r;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r;
  prio_t                   out_prio_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;
  logic [CW-1:0]           out_count_r;

  logic                    out_load;
  logic                    hit;
  logic [IW-1:0]           rd_addr;
  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  prio_t                   mem_wprio;
  logic [PAYLOAD_BITS-1:0] mem_wpay;

  always_comb begin
    case (act_r)
      ACT_POP_FRONT: hit = 1'b1;
      ACT_POP_EXACT: hit = (rd_prio_r == key_r);
      ACT_POP_MIN:   hit = (rd_prio_r >= key_r);
      default:       hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    chk_vld_nxt    = chk_vld_r;
    chk_idx_nxt    = chk_idx_r;
    src_nxt        = src_r;
    wr_pend_nxt    = wr_pend_r;
    wr_idx_nxt     = wr_idx_r;
    res_status_nxt = res_status_r;
    res_prio_nxt   = res_prio_r;
    res_pay_nxt    = res_pay_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_load       = 1'b0;
    rd_addr        = idx_r[IW-1:0];
    mem_we         = 1'b0;
    mem_waddr      = wr_idx_r;
    mem_wprio      = rd_prio_r;
    mem_wpay       = rd_pay_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          act_nxt        = in_ch.action;
          key_nxt        = in_ch.priority_req;
          res_status_nxt = ST_OK;
          res_prio_nxt   = '0;
          res_pay_nxt    = '0;
          idx_nxt        = '0;
          chk_vld_nxt    = 1'b0;
          state_nxt      = S_DONE;
          case (in_ch.action)
            ACT_PUSH: begin
              if (count_r >= CW'(DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_r[IW-1:0];
                mem_wprio = in_ch.priority_req;
                mem_wpay  = in_ch.payload;
                count_nxt = count_r + CW'(1);
              end
            end
            ACT_POP_FRONT, ACT_POP_EXACT, ACT_POP_MIN: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        rd_addr = idx_r[IW-1:0];
        if (chk_vld_r && hit) begin
          res_prio_nxt = rd_prio_r;
          res_pay_nxt  = rd_pay_r;
          src_nxt      = CW'(chk_idx_r) + CW'(1);
          wr_pend_nxt  = 1'b0;
          chk_vld_nxt  = 1'b0;
          state_nxt    = S_SHIFT;
        end else if (idx_r < count_r) begin
          idx_nxt     = idx_r + CW'(1);
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = idx_r[IW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
          if (!chk_vld_r) begin
            res_status_nxt = ST_NOT_FOUND;
            state_nxt      = S_DONE;
          end
        end
      end
      S_SHIFT: begin
        rd_addr = src_r[IW-1:0];
        if (wr_pend_r) begin
          mem_we = 1'b1;
        end
        if (src_r < count_r) begin
          src_nxt     = src_r + CW'(1);
          wr_idx_nxt  = IW'(src_r - CW'(1));
          wr_pend_nxt = 1'b1;
        end else begin
          wr_pend_nxt = 1'b0;
          if (!wr_pend_r) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_prio[mem_waddr] <= mem_wprio;
      mem_pay[mem_waddr]  <= mem_wpay;
    end
    rd_prio_r <= mem_prio[rd_addr];
    rd_pay_r  <= mem_pay[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      chk_vld_r   <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      chk_vld_r   <= chk_vld_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    src_r        <= src_nxt;
    wr_idx_r     <= wr_idx_nxt;
    res_status_r <= res_status_nxt;
    res_prio_r   <= res_prio_nxt;
    res_pay_r    <= res_pay_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_prio_r   <= res_prio_r;
      out_pay_r    <= res_pay_r;
      out_count_r  <= count_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.out_priority = out_prio_r;
  assign out_ch.out_payload  = out_pay_r;
  assign out_ch.count        = out_count_r;

endmodule
`default_nettype wire

// ----- bench/fifo_with_priority_extraction_tb.sv -----
// Testbench for the message queue: directed and random requests checked against a shadow queue.
module fifo_with_priority_extraction_tb;
  import fwpe_pkg::*;

  localparam int QUEUE_DEPTH = 16;
  localparam int PAYLOAD_W   = 32;
  localparam int COUNT_W     = 5;
  localparam int RANDOM_ITEMS_PER_PHASE = 338;

  typedef struct packed {
    status_t                status;
    prio_t                  prio;
    logic [PAYLOAD_W-1:0]   payload;
    logic [COUNT_W-1:0]     count;
  } reply_t;

  class queue_shadow;
    prio_t                slot_prio[$];
    logic [PAYLOAD_W-1:0] slot_payload[$];
    reply_t               expected_replies[$];
    int                   errors;

    function new();
      errors = 0;
    endfunction

    function void note_request(action_t act, prio_t key, logic [PAYLOAD_W-1:0] body);
      reply_t r;
      int     hit;
      r = '0;
      r.status = ST_OK;
      hit = -1;
      case (act)
        ACT_PUSH: begin
          if (slot_prio.size() >= QUEUE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            slot_prio.push_back(key);
            slot_payload.push_back(body);
          end
        end
        ACT_POP_FRONT, ACT_POP_EXACT, ACT_POP_MIN: begin
          if (slot_prio.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            for (int i = 0; i < slot_prio.size(); i++) begin
              if (hit < 0 && (act == ACT_POP_FRONT ||
                  (act == ACT_POP_EXACT && slot_prio[i] == key) ||
                  (act == ACT_POP_MIN && slot_prio[i] >= key))) begin
                hit = i;
              end
            end
            if (hit < 0) begin
              r.status = ST_NOT_FOUND;
            end else begin
              r.prio    = slot_prio[hit];
              r.payload = slot_payload[hit];
              slot_prio.delete(hit);
              slot_payload.delete(hit);
            end
          end
        end
        ACT_CLEAR: begin
          slot_prio.delete();
          slot_payload.delete();
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'(slot_prio.size());
      expected_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch("result arrived with no request pending");
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.prio !== want.prio)
        report_mismatch($sformatf("priority got %0d want %0d", got.prio, want.prio));
      if (got.payload !== want.payload)
        report_mismatch($sformatf("payload got %h want %h", got.payload, want.payload));
      if (got.count !== want.count)
        report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  queue_shadow sb;
  reply_t seen;

  fwpe_in_if  #(.PAYLOAD_BITS(PAYLOAD_W)) in_ch ();
  fwpe_out_if #(.PAYLOAD_BITS(PAYLOAD_W), .CNT_BITS(COUNT_W)) out_ch ();

  fifo_with_priority_extraction #(
    .DEPTH        (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_W)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = '{out_ch.status, out_ch.out_priority, out_ch.out_payload, out_ch.count};
      sb.check_result(seen);
    end
  end

  task automatic send_request(input action_t act, input prio_t key,
                              input logic [PAYLOAD_W-1:0] body);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.action       = act;
    in_ch.priority_req = key;
    in_ch.payload      = body;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(act, key, body);
    @(negedge clk);
  endtask

  function automatic prio_t random_prio();
    int r;
    r = $urandom_range(99);
    if (r < 40) return prio_t'($urandom_range(255));
    if (r < 70) begin
      case ($urandom_range(3))
        0: return 8'd0;
        1: return 8'd1;
        2: return 8'd254;
        default: return 8'd255;
      endcase
    end
    return prio_t'($urandom_range(15));
  endfunction

  function automatic logic [PAYLOAD_W-1:0] random_body();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  // Fill mode mostly pushes, drain mode mostly pops, mixed mode balances the two.
  task automatic issue_random_request(input int mode);
    int      roll;
    int      push_pct;
    action_t act;
    prio_t   key;
    push_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
    roll = $urandom_range(99);
    if (roll < 2) begin
      act = ACT_CLEAR;
    end else if (roll < 4) begin
      act = action_t'($urandom_range(5, 7));
    end else if (roll < 4 + push_pct) begin
      act = ACT_PUSH;
    end else begin
      case ($urandom_range(2))
        0: act = ACT_POP_FRONT;
        1: act = ACT_POP_EXACT;
        default: act = ACT_POP_MIN;
      endcase
    end
    if ((act == ACT_POP_EXACT || act == ACT_POP_MIN) && sb.slot_prio.size() > 0 &&
        $urandom_range(99) < 70) begin
      key = sb.slot_prio[$urandom_range(sb.slot_prio.size() - 1)];
    end else begin
      key = random_prio();
    end
    send_request(act, key, random_body());
  endtask

  initial begin
    int mode;
    sb = new();
    rst_n              = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    in_ch.valid        = 1'b0;
    in_ch.action       = ACT_PUSH;
    in_ch.priority_req = '0;
    in_ch.payload      = '0;
    out_ch.ready       = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_request(ACT_POP_FRONT, 8'd0, '0);
    send_request(ACT_POP_EXACT, 8'd3, '0);
    send_request(ACT_POP_MIN, 8'd0, '1);
    send_request(ACT_PUSH, 8'd0, '0);
    send_request(ACT_PUSH, 8'd255, '1);
    send_request(ACT_PUSH, 8'd128, 32'ha5a5_a5a5);
    send_request(ACT_PUSH, 8'd128, 32'h5a5a_5a5a);
    send_request(ACT_POP_EXACT, 8'd128, '0);
    send_request(ACT_POP_EXACT, 8'd7, '0);
    send_request(ACT_POP_MIN, 8'd255, '0);
    send_request(ACT_POP_MIN, 8'd129, '0);
    send_request(ACT_POP_FRONT, 8'd0, '0);
    send_request(ACT_POP_MIN, 8'd0, '0);
    send_request(action_t'(5), 8'hff, '1);
    send_request(action_t'(6), 8'h55, 32'h1234_5678);
    send_request(action_t'(7), 8'haa, 32'hdead_beef);
    send_request(ACT_PUSH, 8'd9, 32'h0000_0001);
    send_request(ACT_PUSH, 8'd10, 32'h8000_0000);
    send_request(ACT_CLEAR, 8'd0, '0);
    send_request(ACT_POP_FRONT, 8'd0, '0);

    mode = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
        default: begin sender_idle_pct = 29; receiver_stall_pct = 29; end
      endcase
      for (int n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
        if (n % 40 == 0) mode = $urandom_range(2);
        if (n == RANDOM_ITEMS_PER_PHASE / 2) begin
          in_ch.valid = 1'b0;
          while (sb.expected_replies.size() != 0) @(negedge clk);
        end
        issue_random_request(mode);
      end
    end

    in_ch.valid = 1'b0;
    while (sb.expected_replies.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (sb.errors == 0) begin
      $display("fifo_with_priority_extraction test passed");
    end else begin
      $display("fifo_with_priority_extraction test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("fifo_with_priority_extraction test failed");
    $finish;
  end

endmodule
